// File: src/swms_pkg.sv
// ============================================================================
// swms_pkg
// Shared constants for the sliding-window mean and deviation block.
// ============================================================================
`default_nettype none

package swms_pkg;

    localparam int WINDOW_MAX   = 128;
    localparam int WINDOW_RESET = 100;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 8;
    localparam int PTR_W    = $clog2(WINDOW_MAX);
    localparam int FILL_W   = $clog2(WINDOW_MAX + 1);

    // Running accumulators: sum of up to WINDOW_MAX samples and of their squares
    localparam int SUM_W    = SAMPLE_W + PTR_W + 1;
    localparam int SQSUM_W  = 2 * SAMPLE_W + PTR_W - 1;

endpackage

`default_nettype wire

// File: src/swms_ram.sv
// ============================================================================
// swms_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module swms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/sliding_window_mean_stddev.sv
// ============================================================================
// sliding_window_mean_stddev
// Running mean and population standard deviation over the last N samples.
//
// Usage:
//   Input channel (sample_valid / sample_stall / sample) carries one signed
//   Q8.8 sample per transfer. Output channel (result_valid / result_stall)
//   carries mean, deviation and valid_res, one result per sample.
//   Config channel (cfg_valid / cfg_ready / window_length) sets N (0 reads
//   as 1, above 128 reads as 128) and empties the window; it is taken only
//   while the block is idle.
//   Until N samples are held, results carry valid_res = 0 and zero fields;
//   such an item passes through the square, add and output steps only.
//   Once the window is full, each item runs the long path: a
//   shared 24x24 multiplier forms the squares and N*sumsq over 9 sequencer
//   steps, then a shared subtractor runs 23 steps of sum/N, 46 steps of the
//   variance division by N*N and 23 steps of the square root.
//   The sample input stalls until the block is back in idle.
//   Reset sets N = 100 and an empty window. The result sits in an output
//   register; a stalled receiver holds it, and the block still accepts and
//   works the next sample, waiting at the end until the register frees up.
// ============================================================================
`default_nettype none

module sliding_window_mean_stddev (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sample_valid,
    output logic                                    sample_stall,
    input  wire logic signed [swms_pkg::SAMPLE_W-1:0] sample,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic signed [swms_pkg::SAMPLE_W-1:0]    mean,
    output logic        [swms_pkg::SAMPLE_W-1:0]    deviation,
    output logic                                    valid_res,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic   [swms_pkg::LEN_W-1:0]       window_length
);

    import swms_pkg::*;

    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MAG_W  = SUM_W - 1;          // |sum| fits one bit less
    localparam int NUM_W  = 2 * MAG_W;          // N*sumsq and sum^2
    localparam int DVS_W  = 2 * LEN_W - 1;      // N*N
    localparam int ROOT_W = NUM_W / 2;
    localparam int SQR_W  = ROOT_W + 1;
    localparam int SUB_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    typedef enum logic [14:0] {
        ST_IDLE     = 15'b000000000000001,
        ST_OLD_SQ   = 15'b000000000000010,
        ST_OLD_SUB  = 15'b000000000000100,
        ST_NEW_SQ   = 15'b000000000001000,
        ST_NEW_ADD  = 15'b000000000010000,
        ST_SUM_SQ   = 15'b000000000100000,
        ST_A_LO     = 15'b000000001000000,
        ST_A_HI     = 15'b000000010000000,
        ST_A_SUM    = 15'b000000100000000,
        ST_DIFF_NN  = 15'b000001000000000,
        ST_MEAN_DIV = 15'b000010000000000,
        ST_VAR_LOAD = 15'b000100000000000,
        ST_VAR_DIV  = 15'b001000000000000,
        ST_SQRT     = 15'b010000000000000,
        ST_OUT      = 15'b100000000000000
    } state_t;

    function automatic logic [SAMPLE_W-1:0] mag16(input logic [SAMPLE_W-1:0] x);
        mag16 = x[SAMPLE_W-1] ? (~x + 1'b1) : x;
    endfunction

    // Control state
    state_t                 state_reg,   state_next;
    logic [LEN_W-1:0]       n_reg,       n_next;
    logic [FILL_W-1:0]      fill_reg,    fill_next;
    logic [PTR_W-1:0]       ptr_reg,     ptr_next;
    logic [SUM_W-1:0]       sum_reg,     sum_next;
    logic [SQSUM_W-1:0]     sumsq_reg,   sumsq_next;
    logic [CNT_W-1:0]       cnt_reg,     cnt_next;
    logic                   full_reg,    full_next;
    logic                   ok_reg,      ok_next;
    logic                   ovalid_reg,  ovalid_next;

    // Datapath
    logic [SAMPLE_W-1:0]    smp_reg,     smp_next;
    logic [PTR_W-1:0]       slot_reg,    slot_next;
    logic [SAMPLE_W-1:0]    old_reg,     old_next;
    logic [PROD_W-1:0]      prod_reg,    prod_next;
    logic [NUM_W-1:0]       acc_reg,     acc_next;
    logic [NUM_W-1:0]       b_reg,       b_next;
    logic [NUM_W-1:0]       quo_reg,     quo_next;
    logic [DVS_W-1:0]       rem_reg,     rem_next;
    logic [DVS_W-1:0]       dvs_reg,     dvs_next;
    logic [ROOT_W-1:0]      root_reg,    root_next;
    logic [SQR_W-1:0]       sqr_reg,     sqr_next;
    logic [SAMPLE_W-1:0]    mres_reg,    mres_next;
    logic [SAMPLE_W-1:0]    omean_reg,   omean_next;
    logic [SAMPLE_W-1:0]    odev_reg,    odev_next;
    logic                   ook_reg,     ook_next;

    logic                   in_xfer, cfg_xfer, out_xfer, idle;
    logic [SAMPLE_W-1:0]    ram_rdata;
    logic                   ram_we;

    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [SUB_W-1:0]       sub_a, sub_b;
    logic [SUB_W:0]         sub_diff;
    logic                   sub_ge;

    logic [SUM_W-1:0]       sum_mag;
    logic [SUM_W-1:0]       smp_ext, old_ext;
    logic [DVS_W:0]         div_shift;
    logic [SQR_W+1:0]       sqr_shift;
    logic [NUM_W:0]         var_diff;
    logic [LEN_W-1:0]       ptr_inc;
    logic [FILL_W-1:0]      fill_inc;
    logic [LEN_W-1:0]       len_clamped;

    assign idle         = (state_reg == ST_IDLE);
    assign cfg_ready    = idle;
    assign sample_stall = !idle || cfg_valid;
    assign in_xfer      = sample_valid && !sample_stall;
    assign cfg_xfer     = cfg_valid && cfg_ready;
    assign out_xfer     = ovalid_reg && !result_stall;

    assign result_valid = ovalid_reg;
    assign mean         = omean_reg;
    assign deviation    = odev_reg;
    assign valid_res    = ook_reg;

    assign sum_mag  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign smp_ext  = {{(SUM_W-SAMPLE_W){smp_reg[SAMPLE_W-1]}}, smp_reg};
    assign old_ext  = {{(SUM_W-SAMPLE_W){old_reg[SAMPLE_W-1]}}, old_reg};
    assign ptr_inc  = LEN_W'(ptr_reg) + 1'b1;
    assign fill_inc = fill_reg + 1'b1;
    assign var_diff = {1'b0, acc_reg} - {1'b0, b_reg};

    always_comb
    begin
        if (window_length == '0)
        begin
            len_clamped = LEN_W'(1);
        end
        else if (FILL_W'(window_length) > FILL_W'(WINDOW_MAX))
        begin
            len_clamped = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_clamped = window_length;
        end
    end

    // Ring of recent samples; the oldest entry is read as the item is taken
    swms_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (smp_reg),
        .re    (in_xfer),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign ram_we = (state_reg == ST_NEW_SQ);

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_OLD_SQ:
            begin
                mul_a = MUL_W'(mag16(ram_rdata));
                mul_b = MUL_W'(mag16(ram_rdata));
            end
            ST_NEW_SQ:
            begin
                mul_a = MUL_W'(mag16(smp_reg));
                mul_b = MUL_W'(mag16(smp_reg));
            end
            ST_SUM_SQ:
            begin
                mul_a = MUL_W'(sum_mag[MAG_W-1:0]);
                mul_b = MUL_W'(sum_mag[MAG_W-1:0]);
            end
            ST_A_LO:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = sumsq_reg[MUL_W-1:0];
            end
            ST_A_HI:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = MUL_W'(sumsq_reg[SQSUM_W-1:MUL_W]);
            end
            ST_DIFF_NN:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = MUL_W'(n_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared subtractor for the restoring divider and the square root
    assign div_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign sqr_shift = {sqr_reg, quo_reg[NUM_W-1 -: 2]};

    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            sub_a = SUB_W'(sqr_shift);
            sub_b = SUB_W'({root_reg, 2'b01});
        end
        else
        begin
            sub_a = SUB_W'(div_shift);
            sub_b = SUB_W'(dvs_reg);
        end
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[SUB_W];

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        fill_next   = fill_reg;
        ptr_next    = ptr_reg;
        sum_next    = sum_reg;
        sumsq_next  = sumsq_reg;
        cnt_next    = cnt_reg;
        full_next   = full_reg;
        ok_next     = ok_reg;
        ovalid_next = ovalid_reg && !out_xfer;

        smp_next    = smp_reg;
        slot_next   = slot_reg;
        old_next    = old_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        b_next      = b_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        root_next   = root_reg;
        sqr_next    = sqr_reg;
        mres_next   = mres_reg;
        omean_next  = omean_reg;
        odev_next   = odev_reg;
        ook_next    = ook_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_xfer)
                begin
                    n_next     = len_clamped;
                    fill_next  = '0;
                    ptr_next   = '0;
                    sum_next   = '0;
                    sumsq_next = '0;
                end
                else if (in_xfer)
                begin
                    smp_next  = sample;
                    full_next = (fill_reg >= FILL_W'(n_reg));
                    if (fill_reg >= FILL_W'(n_reg))
                    begin
                        slot_next  = ptr_reg;
                        state_next = ST_OLD_SQ;
                    end
                    else
                    begin
                        // ptr stays at zero while the window fills
                        slot_next  = fill_reg[PTR_W-1:0];
                        state_next = ST_NEW_SQ;
                    end
                end
            end
            ST_OLD_SQ:
            begin
                old_next   = ram_rdata;
                prod_next  = mul_a * mul_b;
                state_next = ST_OLD_SUB;
            end
            ST_OLD_SUB:
            begin
                sum_next   = sum_reg - old_ext;
                sumsq_next = sumsq_reg - prod_reg[SQSUM_W-1:0];
                ptr_next   = (ptr_inc == n_reg) ? '0 : ptr_inc[PTR_W-1:0];
                state_next = ST_NEW_SQ;
            end
            ST_NEW_SQ:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_NEW_ADD;
            end
            ST_NEW_ADD:
            begin
                sum_next   = sum_reg + smp_ext;
                sumsq_next = sumsq_reg + prod_reg[SQSUM_W-1:0];
                if (!full_reg)
                begin
                    fill_next = fill_inc;
                end
                ok_next = full_reg || (fill_inc == FILL_W'(n_reg));
                if (full_reg || (fill_inc == FILL_W'(n_reg)))
                begin
                    state_next = ST_SUM_SQ;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SUM_SQ:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_A_LO;
            end
            ST_A_LO:
            begin
                b_next     = prod_reg[NUM_W-1:0];
                prod_next  = mul_a * mul_b;
                state_next = ST_A_HI;
            end
            ST_A_HI:
            begin
                acc_next   = prod_reg[NUM_W-1:0];
                prod_next  = mul_a * mul_b;
                state_next = ST_A_SUM;
            end
            ST_A_SUM:
            begin
                acc_next   = acc_reg + {prod_reg[NUM_W-MUL_W-1:0], {MUL_W{1'b0}}};
                state_next = ST_DIFF_NN;
            end
            ST_DIFF_NN:
            begin
                // Clamp a negative variance numerator to zero
                acc_next   = var_diff[NUM_W] ? '0 : var_diff[NUM_W-1:0];
                prod_next  = mul_a * mul_b;
                quo_next   = {sum_mag[MAG_W-1:0], {(NUM_W-MAG_W){1'b0}}};
                rem_next   = '0;
                dvs_next   = DVS_W'(n_reg);
                cnt_next   = CNT_W'(MAG_W);
                state_next = ST_MEAN_DIV;
            end
            ST_MEAN_DIV:
            begin
                rem_next = sub_ge ? sub_diff[DVS_W-1:0] : div_shift[DVS_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], sub_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_VAR_LOAD;
                end
            end
            ST_VAR_LOAD:
            begin
                mres_next  = sum_reg[SUM_W-1] ? (~quo_reg[SAMPLE_W-1:0] + 1'b1)
                                              : quo_reg[SAMPLE_W-1:0];
                quo_next   = acc_reg;
                rem_next   = '0;
                dvs_next   = prod_reg[DVS_W-1:0];
                cnt_next   = CNT_W'(NUM_W);
                state_next = ST_VAR_DIV;
            end
            ST_VAR_DIV:
            begin
                rem_next = sub_ge ? sub_diff[DVS_W-1:0] : div_shift[DVS_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], sub_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    root_next  = '0;
                    sqr_next   = '0;
                    cnt_next   = CNT_W'(ROOT_W);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // One root bit per step, two radicand bits shifted in
                sqr_next  = sub_ge ? sub_diff[SQR_W-1:0] : sqr_shift[SQR_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                quo_next  = {quo_reg[NUM_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!ovalid_reg || !result_stall)
                begin
                    ovalid_next = 1'b1;
                    ook_next    = ok_reg;
                    if (ok_reg)
                    begin
                        omean_next = mres_reg;
                        odev_next  = (root_reg[ROOT_W-1:SAMPLE_W] != '0) ? '1
                                                                        : root_reg[SAMPLE_W-1:0];
                    end
                    else
                    begin
                        omean_next = '0;
                        odev_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            n_reg      <= LEN_W'(WINDOW_RESET);
            fill_reg   <= '0;
            ptr_reg    <= '0;
            sum_reg    <= '0;
            sumsq_reg  <= '0;
            cnt_reg    <= '0;
            full_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            fill_reg   <= fill_next;
            ptr_reg    <= ptr_next;
            sum_reg    <= sum_next;
            sumsq_reg  <= sumsq_next;
            cnt_reg    <= cnt_next;
            full_reg   <= full_next;
            ok_reg     <= ok_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        slot_reg  <= slot_next;
        old_reg   <= old_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        b_reg     <= b_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        root_reg  <= root_next;
        sqr_reg   <= sqr_next;
        mres_reg  <= mres_next;
        omean_reg <= omean_next;
        odev_reg  <= odev_next;
        ook_reg   <= ook_next;
    end

endmodule

`default_nettype wire

// File: tb/tb_sliding_window_mean_stddev.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_sliding_window_mean_stddev
// Self-checking bench for the sliding-window mean and deviation block.
//
// A scoreboard object keeps its own window of samples, running sum and sum of
// squares. For every sample transfer it predicts mean, deviation and the
// window-full flag. Each result transfer is compared field by field against
// the oldest prediction. The run covers the reset window length, directed
// extremes at short windows, saturated and random lengths, random gaps and
// stalls, and one long receiver hold-off.
// ============================================================================

module tb_sliding_window_mean_stddev;

    import swms_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int LIMIT        = 400000;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 300;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic        [SAMPLE_W-1:0] deviation;
        logic                       valid_res;
    } window_result_t;

    // Predicts window statistics and holds the results still owed by the block
    class window_stats_board;
        sample_t           ring [WINDOW_MAX];
        int unsigned       length;
        int unsigned       oldest;
        int unsigned       fill;
        longint            sum;
        longint unsigned   square_sum;
        window_result_t    owed_q [$];
        int unsigned       fails;

        function new();
            length = WINDOW_RESET;
            fails  = 0;
            empty_window();
        endfunction

        function void empty_window();
            oldest     = 0;
            fill       = 0;
            sum        = 0;
            square_sum = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] value);
            if (value == 0)
                length = 1;
            else if (value > WINDOW_MAX)
                length = WINDOW_MAX;
            else
                length = value;
            empty_window();
        endfunction

        function longint unsigned floor_root(longint unsigned x);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int i = 31; i >= 0; i--)
            begin
                trial = r | (64'd1 << i);
                if (trial * trial <= x)
                    r = trial;
            end
            return r;
        endfunction

        function void note_sample(sample_t s);
            int unsigned     slot;
            longint          held;
            longint          value;
            longint          avg;
            longint unsigned mag;
            longint unsigned spread;
            longint unsigned dev;
            window_result_t  want;

            value = s;
            if (fill >= length)
            begin
                // drop the oldest sample before adding the new one
                slot        = oldest % length;
                held        = ring[slot];
                sum        -= held;
                square_sum -= $unsigned(held * held);
                oldest      = (slot + 1) % length;
            end
            else
            begin
                slot = (oldest + fill) % length;
                fill++;
            end
            ring[slot]  = s;
            sum        += value;
            square_sum += $unsigned(value * value);

            want = '0;
            if (fill >= length)
            begin
                avg    = sum / longint'(length);
                mag    = (sum < 0) ? $unsigned(-sum) : $unsigned(sum);
                spread = 0;
                if (longint'(length) * square_sum > mag * mag)
                    spread = (longint'(length) * square_sum - mag * mag)
                             / (longint'(length) * longint'(length));
                dev = floor_root(spread);
                if (dev > 64'hFFFF)
                    dev = 64'hFFFF;
                want.mean      = avg[SAMPLE_W-1:0];
                want.deviation = dev[SAMPLE_W-1:0];
                want.valid_res = 1'b1;
            end
            owed_q = {owed_q, want};
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] mean,
                                   logic [SAMPLE_W-1:0] deviation,
                                   logic valid_res);
            window_result_t want;
            if (owed_q.size() == 0)
            begin
                $error("result with no sample outstanding: mean %0d deviation %0d valid_res %0b",
                       mean, deviation, valid_res);
                fails++;
                return;
            end
            want = owed_q.pop_front();
            if (mean !== want.mean)
            begin
                $error("mean: expected %0d, actual %0d", want.mean, mean);
                fails++;
            end
            if (deviation !== want.deviation)
            begin
                $error("deviation: expected %0d, actual %0d", want.deviation, deviation);
                fails++;
            end
            if (valid_res !== want.valid_res)
            begin
                $error("valid_res: expected %0b, actual %0b", want.valid_res, valid_res);
                fails++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     sample_valid;
    logic                     sample_stall;
    sample_t                  sample;
    logic                     result_valid;
    logic                     result_stall;
    logic signed [SAMPLE_W-1:0] mean;
    logic        [SAMPLE_W-1:0] deviation;
    logic                     valid_res;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic        [LEN_W-1:0]  window_length;

    window_stats_board board = new();

    int  stall_pct = 0;
    bit  quiet     = 1'b0;
    bit  hold_long = 1'b0;
    int  cycles    = 0;

    sliding_window_mean_stddev i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .mean          (mean),
        .deviation     (deviation),
        .valid_res     (valid_res),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[sliding_window_mean_stddev] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_result(mean, deviation, valid_res);
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin : receiver
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                hold_long = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic sample_t pick_sample();
        int unsigned r;
        sample_t     s;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0:       s = 16'sh8000;
                1:       s = 16'sh7FFF;
                2:       s = 16'sh0000;
                default: s = -16'sd1;
            endcase
        end
        else if (r < 40)
            s = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
        else
            s = sample_t'($urandom);
        return s;
    endfunction

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Offer one sample and hold it until the block takes it
    task automatic send_sample(input sample_t s);
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (sample_stall);
        board.note_sample(s);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        wait_drained();
        cfg_valid     <= 1'b1;
        window_length <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_length(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int gap_pct, input int stalls,
                             input int pause_at);
        stall_pct = stalls;
        for (int i = 0; i < count; i++)
        begin
            send_sample(pick_sample());
            if (i == pause_at)
            begin
                // hold off until every owed result has come back
                sample_valid <= 1'b0;
                wait_drained();
            end
            else if (i != count - 1 && !quiet && $urandom_range(0, 99) < gap_pct)
            begin
                sample_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
        sample_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        sample_valid  <= 1'b0;
        sample        <= '0;
        cfg_valid     <= 1'b0;
        window_length <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window length: extremes while the window fills, then random
        stall_pct = 25;
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        run_phase(140, 25, 25, -1);

        // Zero length reads as one: every result is valid and equals the sample
        write_length(8'd0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(-16'sd1);
        send_sample(16'sh0000);
        sample_valid <= 1'b0;

        // Two-sample window at full scale swing: largest deviation
        write_length(8'd2);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        sample_valid <= 1'b0;

        // Saturated length, with a pause mid-phase
        write_length(8'd255);
        run_phase(200, 10, 30, 100);

        // Short window, receiver holds off long so the input backs up
        write_length(8'd7);
        hold_long = 1'b1;
        run_phase(80, 0, 15, -1);

        write_length(8'd128);
        run_phase(140, 40, 0, -1);

        write_length(8'($urandom_range(1, 40)));
        run_phase(80, 20, 20, -1);

        // Last stretch runs without any idling
        write_length(8'd1);
        quiet     = 1'b1;
        stall_pct = 0;
        run_phase(60, 0, 0, -1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.fails == 0 && board.pending() == 0)
            $display("[sliding_window_mean_stddev] OK");
        else
            $display("[sliding_window_mean_stddev] ERROR");
        $finish;
    end

endmodule
